// File: src/scfd_pkg.sv
package scfd_pkg;

    // Frame layout.
    localparam int unsigned PAYLOAD_BYTES = 12;
    localparam int unsigned WORD_COUNT    = 3;
    localparam logic [7:0]  CRC_POLY      = 8'h07;

    // Register reset values and the age ceiling.
    localparam logic [7:0]  RESET_SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  RESET_SYNC_SECOND = 8'h5A;
    localparam logic [15:0] RESET_TIMEOUT     = 16'd1000;
    localparam logic [15:0] AGE_MAX           = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    // Request type codes.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Deframer phase.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    // One byte through the CRC-8 register, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/sync_crc8_frame_deframer_unit.sv
// Sync-word deframer with CRC-8 check and a freshness timeout. Each request is
// either one received byte or one millisecond tick, and each request gives
// exactly one result carrying the frame flags, the valid flag and the last good
// payload words. The block takes one request per cycle while the output is not
// stalled; a request lands in an input register, the deframer logic and CRC
// update work on it from there, and the result is registered in the output
// register. Requests keep flowing as long as the output side takes results; a
// stalled output holds the pipeline. Configuration is written through the APB
// port at byte addresses 0 (first sync byte), 4 (second sync byte) and 8
// (timeout in ticks) and should only be changed while no request is in flight.
module sync_crc8_frame_deframer_unit
    import scfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_ok,
    output logic        crc_error,
    output logic        data_valid,
    output logic [31:0] vel_x_bits,
    output logic [31:0] vel_y_bits,
    output logic [31:0] yaw_rate_bits,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  reg_index;
    logic        cfg_write;

    // Input stage.
    logic        in_valid_reg;
    logic        req_type_reg;
    logic [7:0]  rx_byte_reg;

    // Deframer state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] payload_reg [WORD_COUNT];
    logic        payload_we;
    logic [1:0]  payload_word;
    logic [1:0]  payload_lane;
    logic [31:0] latched_reg [WORD_COUNT];
    logic        latch_en;
    logic        valid_reg, valid_next;
    logic [15:0] age_reg, age_next;
    logic        ok_next, err_next;

    // Output stage.
    logic        out_valid_reg;
    logic        ok_reg, err_reg, dvalid_reg;

    logic        advance;
    logic        fire;

    // Pipeline control: the compute stage moves when the output slot is free or its result is being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= RESET_SYNC_FIRST;
            sync_second_reg <= RESET_SYNC_SECOND;
            timeout_reg     <= RESET_TIMEOUT;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                REG_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                REG_TIMEOUT:     timeout_reg     <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        case (reg_index)
            REG_SYNC_FIRST:  prdata = {24'd0, sync_first_reg};
            REG_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            REG_TIMEOUT:     prdata = {16'd0, timeout_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_type_reg <= req_type;
            rx_byte_reg  <= rx_byte;
        end
    end

    // Deframer next-state logic for one request.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        age_next     = age_reg;
        valid_next   = valid_reg;
        ok_next      = 1'b0;
        err_next     = 1'b0;
        payload_we   = 1'b0;
        latch_en     = 1'b0;
        payload_word = count_reg[3:2];
        payload_lane = count_reg[1:0];

        if (req_type_reg == REQ_TICK)
        begin
            if (age_reg != AGE_MAX)
            begin
                age_next = age_reg + 16'd1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte_reg == sync_second_reg)
                    begin
                        phase_next = PH_COLLECT;
                        count_next = 4'd0;
                        crc_next   = crc8_byte(crc8_byte(8'd0, sync_first_reg),
                                               sync_second_reg);
                    end
                    else if (rx_byte_reg != sync_first_reg)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_COLLECT:
                begin
                    if (count_reg < 4'(PAYLOAD_BYTES))
                    begin
                        payload_we = 1'b1;
                        crc_next   = crc8_byte(crc_reg, rx_byte_reg);
                        count_next = count_reg + 4'd1;
                    end
                    else
                    begin
                        if (rx_byte_reg == crc_reg)
                        begin
                            ok_next    = 1'b1;
                            latch_en   = 1'b1;
                            valid_next = 1'b1;
                            age_next   = 16'd0;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                        phase_next = PH_HUNT;
                        count_next = 4'd0;
                    end
                end
                default:
                begin
                    // Hunting, and the unused phase code behaves the same.
                    phase_next = (rx_byte_reg == sync_first_reg) ? PH_WAIT : PH_HUNT;
                end
            endcase
        end

        // Freshness timeout is checked on every request.
        if (valid_next && (age_next > timeout_reg))
        begin
            valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= 4'd0;
            crc_reg   <= 8'd0;
            valid_reg <= 1'b0;
            age_reg   <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    // Frame assembly: one byte lane of one word per payload byte.
    always_ff @(posedge clk)
    begin
        if (fire && payload_we)
        begin
            case (payload_lane)
                2'd0:    payload_reg[payload_word][7:0]   <= rx_byte_reg;
                2'd1:    payload_reg[payload_word][15:8]  <= rx_byte_reg;
                2'd2:    payload_reg[payload_word][23:16] <= rx_byte_reg;
                default: payload_reg[payload_word][31:24] <= rx_byte_reg;
            endcase
        end
    end

    // Last good frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                latched_reg[i] <= 32'd0;
            end
        end
        else if (fire && latch_en)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                latched_reg[i] <= payload_reg[i];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg     <= ok_next;
            err_reg    <= err_next;
            dvalid_reg <= valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_ok      = ok_reg;
    assign crc_error     = err_reg;
    assign data_valid    = dvalid_reg;
    assign vel_x_bits    = latched_reg[0];
    assign vel_y_bits    = latched_reg[1];
    assign yaw_rate_bits = latched_reg[2];

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int REPORT_LIMIT = 10;

    // Index past the last register; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [7:0] payload_t [PAYLOAD_BYTES];

    typedef struct packed {
        logic        frame_ok;
        logic        crc_error;
        logic        data_valid;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] yaw_rate;
    } deframe_result_t;

    // Tracks the deframer state, predicts the result of every accepted request
    // and compares arriving results against the oldest prediction.
    class frame_scoreboard;
        logic [7:0]      sync_first_cfg;
        logic [7:0]      sync_second_cfg;
        logic [15:0]     timeout_cfg;
        phase_t          phase;
        logic [3:0]      count;
        logic [7:0]      crc;
        logic [31:0]     assembling [WORD_COUNT];
        logic [31:0]     held [WORD_COUNT];
        logic            fresh;
        logic [15:0]     age;
        deframe_result_t expected_results [$];
        int              failures;
        int              reported;

        function new();
            sync_first_cfg  = RESET_SYNC_FIRST;
            sync_second_cfg = RESET_SYNC_SECOND;
            timeout_cfg     = RESET_TIMEOUT;
            phase           = PH_HUNT;
            count           = '0;
            crc             = '0;
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                assembling[i] = '0;
                held[i]       = '0;
            end
            fresh    = 1'b0;
            age      = '0;
            failures = 0;
            reported = 0;
        endfunction

        // Bit-serial CRC-8, most significant data bit first.
        static function logic [7:0] crc8_step(input logic [7:0] crc_in,
                                              input logic [7:0] data);
            logic [7:0] c;
            logic       feedback;
            c = crc_in;
            for (int i = 7; i >= 0; i--)
            begin
                feedback = c[7] ^ data[i];
                c = {c[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function void set_register(input logic [1:0] index, input logic [31:0] value);
            case (index)
                REG_SYNC_FIRST:  sync_first_cfg  = value[7:0];
                REG_SYNC_SECOND: sync_second_cfg = value[7:0];
                REG_TIMEOUT:     timeout_cfg     = value[15:0];
                default:         ;
            endcase
        endfunction

        function void note_request(input logic kind, input logic [7:0] b);
            deframe_result_t r;
            int              w;
            int              sh;
            r = '0;
            if (kind == REQ_TICK)
            begin
                if (age != AGE_MAX)
                begin
                    age++;
                end
            end
            else
            begin
                case (phase)
                    PH_WAIT:
                    begin
                        // The second-sync test wins when both sync values match.
                        if (b == sync_second_cfg)
                        begin
                            phase = PH_COLLECT;
                            count = '0;
                            crc   = crc8_step(crc8_step(8'h00, sync_first_cfg),
                                              sync_second_cfg);
                        end
                        else if (b != sync_first_cfg)
                        begin
                            phase = PH_HUNT;
                        end
                    end
                    PH_COLLECT:
                    begin
                        if (count < PAYLOAD_BYTES)
                        begin
                            w  = int'(count[3:2]);
                            sh = int'(count[1:0]);
                            assembling[w][8*sh +: 8] = b;
                            crc   = crc8_step(crc, b);
                            count = count + 4'd1;
                        end
                        else
                        begin
                            if (b == crc)
                            begin
                                r.frame_ok = 1'b1;
                                held       = assembling;
                                fresh      = 1'b1;
                                age        = '0;
                            end
                            else
                            begin
                                r.crc_error = 1'b1;
                            end
                            phase = PH_HUNT;
                            count = '0;
                        end
                    end
                    default:
                    begin
                        phase = (b == sync_first_cfg) ? PH_WAIT : PH_HUNT;
                    end
                endcase
            end

            // The timeout is checked on every request.
            if (fresh && age > timeout_cfg)
            begin
                fresh = 1'b0;
            end

            r.data_valid = fresh;
            r.vel_x      = held[0];
            r.vel_y      = held[1];
            r.yaw_rate   = held[2];
            expected_results.push_back(r);
        endfunction

        function void check_result(input deframe_result_t got);
            deframe_result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("unexpected result: ok=%0b err=%0b valid=%0b x=%h y=%h yaw=%h",
                             got.frame_ok, got.crc_error, got.data_valid,
                             got.vel_x, got.vel_y, got.yaw_rate);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.frame_ok !== want.frame_ok || got.crc_error !== want.crc_error ||
                got.data_valid !== want.data_valid || got.vel_x !== want.vel_x ||
                got.vel_y !== want.vel_y || got.yaw_rate !== want.yaw_rate)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("mismatch expected: ok=%0b err=%0b valid=%0b x=%h y=%h yaw=%h",
                             want.frame_ok, want.crc_error, want.data_valid,
                             want.vel_x, want.vel_y, want.yaw_rate);
                    $display("         actual:   ok=%0b err=%0b valid=%0b x=%h y=%h yaw=%h",
                             got.frame_ok, got.crc_error, got.data_valid,
                             got.vel_x, got.vel_y, got.yaw_rate);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        frame_ok;
    logic        crc_error;
    logic        data_valid;
    logic [31:0] vel_x_bits;
    logic [31:0] vel_y_bits;
    logic [31:0] yaw_rate_bits;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit              idle_on      = 1'b1;
    bit              hold_request = 1'b0;
    int              sent_total   = 0;
    int              cycle_count;
    frame_scoreboard sb;

    sync_crc8_frame_deframer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_ok      (frame_ok),
        .crc_error     (crc_error),
        .data_valid    (data_valid),
        .vel_x_bits    (vel_x_bits),
        .vel_y_bits    (vel_y_bits),
        .yaw_rate_bits (yaw_rate_bits),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Ends a run that hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Every accepted request produces one prediction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note_request(req_type, rx_byte);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result({frame_ok, crc_error, data_valid,
                             vel_x_bits, vel_y_bits, yaw_rate_bits});
        end
    end

    // Result side: short random stall bursts, plus one long hold-off on request.
    initial
    begin : receiver
        int stall_left;
        int burst;
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst      = $urandom_range(1, 3);
                out_stall  <= 1'b1;
                stall_left = burst - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one request, possibly after a short gap, and holds it until accepted.
    task automatic send_request(input logic kind, input logic [7:0] data);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        rx_byte  <= data;
        sent_total++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sends a complete frame under the current sync setting, optionally with
    // extra leading first-sync bytes, ticks mixed in and a damaged CRC.
    task automatic send_frame(input payload_t body, input bit corrupt, input int repeats,
                              input bit ticks_inside);
        logic [7:0] frame_crc;
        repeat (repeats) send_request(REQ_BYTE, sb.sync_first_cfg);
        send_request(REQ_BYTE, sb.sync_first_cfg);
        send_request(REQ_BYTE, sb.sync_second_cfg);
        frame_crc = frame_scoreboard::crc8_step(
            frame_scoreboard::crc8_step(8'h00, sb.sync_first_cfg), sb.sync_second_cfg);
        foreach (body[i])
        begin
            if (ticks_inside && $urandom_range(0, 9) == 0)
            begin
                send_request(REQ_TICK, 8'($urandom));
            end
            send_request(REQ_BYTE, body[i]);
            frame_crc = frame_scoreboard::crc8_step(frame_crc, body[i]);
        end
        if (corrupt)
        begin
            frame_crc = frame_crc ^ 8'($urandom_range(1, 255));
        end
        send_request(REQ_BYTE, frame_crc);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(index, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops offering requests and waits until every predicted result is in.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all registers with junk in the unused upper bits, and pokes the
    // unused address, which must change nothing.
    task automatic configure(input logic [7:0] new_first, input logic [7:0] new_second,
                             input logic [15:0] new_timeout);
        wait_drained();
        write_register(REG_SYNC_FIRST,  ($urandom() & 32'hFFFF_FF00) | 32'(new_first));
        write_register(REG_SYNC_SECOND, ($urandom() & 32'hFFFF_FF00) | 32'(new_second));
        write_register(REG_TIMEOUT,     ($urandom() & 32'hFFFF_0000) | 32'(new_timeout));
        write_register(REG_UNUSED, $urandom());
    endtask

    // Mostly well-formed frames with random content, mixed with ticks, noise
    // and frames that are cut short.
    task automatic random_traffic(input int quota);
        int       start;
        int       pick;
        int       repeats;
        payload_t body;
        start = sent_total;
        while (sent_total - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                foreach (body[i]) body[i] = 8'($urandom);
                repeats = 0;
                if (sb.sync_first_cfg != sb.sync_second_cfg && $urandom_range(0, 3) == 0)
                begin
                    repeats = $urandom_range(1, 2);
                end
                send_frame(body, $urandom_range(0, 4) == 0, repeats, 1'b1);
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 6)) send_request(REQ_TICK, 8'($urandom));
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 4)) send_request(REQ_BYTE, 8'($urandom));
            end
            else
            begin
                send_request(REQ_BYTE, sb.sync_first_cfg);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_request(REQ_BYTE, sb.sync_second_cfg);
                    repeat ($urandom_range(0, 11)) send_request(REQ_BYTE, 8'($urandom));
                end
                else
                begin
                    send_request(REQ_BYTE, 8'($urandom));
                end
            end
        end
    endtask

    initial
    begin : stimulus
        payload_t body;
        int       failures;
        in_valid = 1'b0;
        req_type = REQ_BYTE;
        rx_byte  = 8'h00;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        sb       = new();
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: a tick before any frame, noise, a lone first
        // sync byte, then a good frame that starts with a repeated first sync.
        send_request(REQ_TICK, 8'hFF);
        send_request(REQ_BYTE, 8'h00);
        send_request(REQ_BYTE, RESET_SYNC_FIRST);
        send_request(REQ_BYTE, 8'h00);
        body = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
                 8'h55, 8'hAA, 8'h12, 8'h34, 8'hC3, 8'h3C};
        send_frame(body, 1'b0, 1, 1'b0);
        send_request(REQ_TICK, 8'h00);

        // Lowering the timeout below the current age drops valid on the next tick.
        configure(RESET_SYNC_FIRST, RESET_SYNC_SECOND, 16'd0);
        send_request(REQ_TICK, 8'h00);

        // Random phases over a spread of settings; the first one starts with a
        // long result hold-off so the pipeline backs up into the request side.
        configure(RESET_SYNC_FIRST, RESET_SYNC_SECOND, 16'd3);
        hold_request = 1'b1;
        random_traffic(200);
        configure(8'h00, 8'hFF, 16'd0);
        random_traffic(200);
        configure(8'hFF, 8'h00, 16'hFFFF);
        random_traffic(200);
        configure(8'h3C, 8'h3C, 16'd5);
        random_traffic(200);
        configure(8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)));
        random_traffic(200);
        configure(8'h00, 8'h00, 16'd1);
        random_traffic(200);

        // Last part of the run without any idling.
        idle_on = 1'b0;
        configure(8'hFF, 8'hFF, 16'd2);
        random_traffic(150);

        wait_drained();
        repeat (10) @(posedge clk);
        failures = sb.failures + sb.pending();
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
